// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// File: hw/rtl/bnp_pkg.sv
// ----------------------------------------------------------------------------
// Bus node presence table package
// Types and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bnp_pkg;

  typedef enum logic [1:0] {
    OP_STATUS  = 2'd0,
    OP_INFO    = 2'd1,
    OP_CLEANUP = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  localparam logic CFG_STALE  = 1'b0;
  localparam logic CFG_EXPIRE = 1'b1;

  localparam logic [31:0] STALE_RESET  = 32'd10000000;
  localparam logic [31:0] EXPIRE_RESET = 32'd4000000;

  typedef struct packed {
    logic [31:0] seen;
    logic [31:0] uptime;
    logic [63:0] id_high;
    logic [63:0] id_low;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load_item;
    logic rd_item;
    logic rd_sweep;
    logic check_sweep;
    logic commit_item;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_cleanup;
    logic sweep_last;
  } dp_sts_t;

endpackage

// File: hw/rtl/bnp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/bnp_ctrl.sv
// ----------------------------------------------------------------------------
// Bus node presence table controller
// Sequences item capture, entry read, cleanup sweep and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bnp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  bnp_pkg::dp_sts_t    sts,
  output bnp_pkg::ctrl_cmd_t  cmd
);
  import bnp_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    READ,
    SWEEP_RD,
    SWEEP_CHK,
    EVAL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      IDLE: begin
        cmd.load_item = in_valid;
        if (in_valid) begin
          state_nxt = READ;
        end
      end
      READ: begin
        cmd.rd_item = 1'b1;
        state_nxt   = sts.op_cleanup ? SWEEP_RD : EVAL;
      end
      SWEEP_RD: begin
        cmd.rd_sweep = 1'b1;
        state_nxt    = SWEEP_CHK;
      end
      SWEEP_CHK: begin
        cmd.check_sweep = 1'b1;
        state_nxt       = sts.sweep_last ? EVAL : SWEEP_RD;
      end
      EVAL: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit_item = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != IDLE);
  assign out_valid = out_valid_r;

  `ASSERT_IMPL(a_result_from_eval, clk, rst_n, $rose(out_valid_r), $past(state_r == EVAL), "result raised outside evaluation")
  `ASSERT_NEXT(a_accept_reads, clk, rst_n, state_r == IDLE && in_valid, state_r == READ, "accepted transaction did not start a read")
  `ASSERT_NEXT(a_sweep_ends, clk, rst_n, state_r == SWEEP_CHK && sts.sweep_last, state_r == EVAL, "sweep did not finish after the last slot")

endmodule

// File: hw/rtl/bnp_dp.sv
// ----------------------------------------------------------------------------
// Bus node presence table datapath
// Holds the configuration, captured item, valid bits, entry RAM and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bnp_dp #(
  parameter int NODE_SLOTS = 127
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_node_id,
  input  logic [31:0]         in_now_us,
  input  logic [31:0]         in_uptime_sec,
  input  logic [63:0]         in_uuid_high,
  input  logic [63:0]         in_uuid_low,
  output logic                out_request_info,
  output logic [6:0]          out_request_node_id,
  output logic                out_match_found,
  input  bnp_pkg::ctrl_cmd_t  cmd,
  output bnp_pkg::dp_sts_t    sts
);
  import bnp_pkg::*;

  localparam int SLOT_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

  logic [31:0]           stale_r;
  logic [31:0]           expire_r;
  op_t                   op_r;
  logic [7:0]            node_r;
  logic                  in_range_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [31:0]           now_r;
  logic [31:0]           up_r;
  logic [63:0]           idh_r;
  logic [63:0]           idl_r;
  logic [NODE_SLOTS-1:0] valid_r;
  logic [NODE_SLOTS-1:0] valid_nxt;
  logic [SLOT_W-1:0]     sweep_cnt_r;
  logic                  req_r;
  logic [6:0]            req_node_r;
  logic                  match_r;

  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              ram_we;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic              cur_valid;
  logic [31:0]       age;
  logic [31:0]       sweep_age;
  logic              reset_cond;
  logic              id_equal;

  assign cur_valid  = valid_r[slot_r];
  assign age        = now_r - rd_entry.seen;
  assign sweep_age  = now_r - rd_entry.seen;
  assign reset_cond = !cur_valid || (age > stale_r) || (up_r < rd_entry.uptime);
  assign id_equal   = (rd_entry.id_high == idh_r) && (rd_entry.id_low == idl_r);

  always_comb begin
    ram_we    = 1'b0;
    wr_entry  = rd_entry;
    valid_nxt = valid_r;
    if (cmd.check_sweep && valid_r[sweep_cnt_r] && (sweep_age > expire_r)) begin
      valid_nxt[sweep_cnt_r] = 1'b0;
    end
    if (cmd.commit_item && in_range_r) begin
      unique case (op_r)
        OP_STATUS: begin
          if (reset_cond) begin
            valid_nxt[slot_r] = 1'b0;
          end else begin
            ram_we          = 1'b1;
            wr_entry.seen   = now_r;
            wr_entry.uptime = up_r;
          end
        end
        OP_INFO: begin
          ram_we            = 1'b1;
          wr_entry          = '{seen: now_r, uptime: up_r, id_high: idh_r, id_low: idl_r};
          valid_nxt[slot_r] = 1'b1;
        end
        OP_CLEANUP: begin
        end
        OP_QUERY: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign ram_re    = cmd.rd_item || cmd.rd_sweep;
  assign ram_raddr = cmd.rd_sweep ? sweep_cnt_r : slot_r;

  bnp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r     <= STALE_RESET;
      expire_r    <= EXPIRE_RESET;
      valid_r     <= '0;
      sweep_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STALE) begin
          stale_r <= cfg_wdata;
        end else begin
          expire_r <= cfg_wdata;
        end
      end
      valid_r <= valid_nxt;
      if (cmd.load_item) begin
        sweep_cnt_r <= '0;
      end else if (cmd.check_sweep) begin
        sweep_cnt_r <= sweep_cnt_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r       <= op_t'(in_op);
      node_r     <= in_node_id;
      in_range_r <= (in_node_id != 8'd0) && (in_node_id <= 8'(NODE_SLOTS));
      slot_r     <= SLOT_W'(in_node_id - 8'd1);
      now_r      <= in_now_us;
      up_r       <= in_uptime_sec;
      idh_r      <= in_uuid_high;
      idl_r      <= in_uuid_low;
    end
    if (cmd.commit_item) begin
      req_r      <= 1'b0;
      req_node_r <= 7'd0;
      match_r    <= 1'b0;
      if (in_range_r && op_r == OP_STATUS && reset_cond) begin
        req_r      <= 1'b1;
        req_node_r <= node_r[6:0];
      end
      if (in_range_r && op_r == OP_QUERY) begin
        match_r <= cur_valid && id_equal;
      end
    end
  end

  assign sts.op_cleanup     = (op_r == OP_CLEANUP);
  assign sts.sweep_last     = (sweep_cnt_r == SLOT_W'(NODE_SLOTS - 1));
  assign out_request_info    = req_r;
  assign out_request_node_id = req_node_r;
  assign out_match_found     = match_r;

  `ASSERT_NEXT(a_info_sets_valid, clk, rst_n, cmd.commit_item && in_range_r && op_r == OP_INFO, valid_r[$past(slot_r)], "info response did not validate the entry")
  `ASSERT_NEXT(a_reset_clears_valid, clk, rst_n, cmd.commit_item && in_range_r && op_r == OP_STATUS && reset_cond, !valid_r[$past(slot_r)], "entry reset left the entry valid")

endmodule

// File: hw/rtl/bus_node_presence_table.sv
// A transaction is accepted in IDLE, reads its entry RAM slot in READ and commits in EVAL,
// where the registered result is raised; in_stall holds new transactions off until IDLE.
// A cleanup tick walks the entry RAM slot by slot, reading each slot and then checking it
// (SWEEP_RD, SWEEP_CHK), before its result is committed in EVAL.
// A stalled earlier result holds EVAL until the receiver takes it.
// Reset (rst_n low, synchronous) clears every valid bit and restores both timeouts.
// ----------------------------------------------------------------------------
// Bus node presence table
// Tracks bus nodes by status and info transactions and answers id queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bus_node_presence_table #(
  parameter int NODE_SLOTS = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_node_id,
  input  logic [31:0] in_now_us,
  input  logic [31:0] in_uptime_sec,
  input  logic [63:0] in_uuid_high,
  input  logic [63:0] in_uuid_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_request_info,
  output logic [6:0]  out_request_node_id,
  output logic        out_match_found
);
  import bnp_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  bnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bnp_dp #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_op               (in_op),
    .in_node_id          (in_node_id),
    .in_now_us           (in_now_us),
    .in_uptime_sec       (in_uptime_sec),
    .in_uuid_high        (in_uuid_high),
    .in_uuid_low         (in_uuid_low),
    .out_request_info    (out_request_info),
    .out_request_node_id (out_request_node_id),
    .out_match_found     (out_match_found),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

// File: dv/presence_table_checker.sv
// ----------------------------------------------------------------------------
// Presence table checker
// Watches the configuration port and both channels of the node presence
// table, predicts each reply from its own copy of the table and timeouts,
// and compares every reply field by field in transaction order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module presence_table_checker #(
  parameter int NODE_SLOTS = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_node_id,
  input  logic [31:0] in_now_us,
  input  logic [31:0] in_uptime_sec,
  input  logic [63:0] in_uuid_high,
  input  logic [63:0] in_uuid_low,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_request_info,
  input  logic [6:0]  out_request_node_id,
  input  logic        out_match_found,
  output int          fail_count,
  output int          outstanding
);
  import bnp_pkg::*;

  typedef struct packed {
    logic       request_info;
    logic [6:0] request_node_id;
    logic       match_found;
  } reply_t;

  logic        node_live [NODE_SLOTS];
  logic [31:0] seen_us   [NODE_SLOTS];
  logic [31:0] uptime_s  [NODE_SLOTS];
  logic [63:0] uid_hi    [NODE_SLOTS];
  logic [63:0] uid_lo    [NODE_SLOTS];
  logic [31:0] stale_us;
  logic [31:0] expire_us;
  reply_t      table_replies [$];
  int          mismatches = 0;

  function automatic void wipe_slot(input int s);
    node_live[s] = 1'b0;
    seen_us[s]   = '0;
    uptime_s[s]  = '0;
    uid_hi[s]    = '0;
    uid_lo[s]    = '0;
  endfunction

  function automatic reply_t table_apply(input op_t op, input logic [7:0] node,
                                         input logic [31:0] now, input logic [31:0] up,
                                         input logic [63:0] idh, input logic [63:0] idl);
    reply_t      r;
    logic [31:0] age;
    int          s;
    r = '0;
    if (op == OP_CLEANUP) begin
      for (int i = 0; i < NODE_SLOTS; i++) begin
        age = now - seen_us[i];
        if (node_live[i] && age > expire_us) wipe_slot(i);
      end
      return r;
    end
    if (node == 8'd0 || node > NODE_SLOTS) return r;
    s = node - 1;
    case (op)
      OP_STATUS: begin
        age = now - seen_us[s];
        if (!node_live[s] || age > stale_us || up < uptime_s[s]) begin
          wipe_slot(s);
          r.request_info    = 1'b1;
          r.request_node_id = node[6:0];
        end else begin
          seen_us[s]  = now;
          uptime_s[s] = up;
        end
      end
      OP_INFO: begin
        uid_hi[s]    = idh;
        uid_lo[s]    = idl;
        seen_us[s]   = now;
        uptime_s[s]  = up;
        node_live[s] = 1'b1;
      end
      OP_QUERY: begin
        r.match_found = node_live[s] && uid_hi[s] == idh && uid_lo[s] == idl;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < NODE_SLOTS; i++) wipe_slot(i);
      stale_us  = STALE_RESET;
      expire_us = EXPIRE_RESET;
      table_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (table_replies.size() == 0) begin
          $error("Reply received with no transaction waiting for one.");
          mismatches++;
        end else begin
          want = table_replies.pop_front();
          if (out_request_info !== want.request_info) begin
            $error("request_info: expected %0d, got %0d", want.request_info,
                   out_request_info);
            mismatches++;
          end
          if (out_request_node_id !== want.request_node_id) begin
            $error("request_node_id: expected %0d, got %0d", want.request_node_id,
                   out_request_node_id);
            mismatches++;
          end
          if (out_match_found !== want.match_found) begin
            $error("match_found: expected %0d, got %0d", want.match_found,
                   out_match_found);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_STALE) stale_us = cfg_wdata;
        else expire_us = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        table_replies.push_back(table_apply(op_t'(in_op), in_node_id, in_now_us,
                                            in_uptime_sec, in_uuid_high, in_uuid_low));
      end
    end
    fail_count  <= mismatches;
    outstanding <= table_replies.size();
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Presence table testbench top
// Drives directed and random bus traffic into the node presence table under
// several timeout settings, with bursty input, random output stalls and one
// long output hold-off, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bnp_pkg::*;

  localparam int NODE_SLOTS      = 127;
  localparam int HOLD_OFF_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [7:0]  in_node_id;
  logic [31:0] in_now_us;
  logic [31:0] in_uptime_sec;
  logic [63:0] in_uuid_high;
  logic [63:0] in_uuid_low;
  logic        out_valid;
  logic        out_stall;
  logic        out_request_info;
  logic [6:0]  out_request_node_id;
  logic        out_match_found;
  int          fail_count;
  int          outstanding;

  bit          hold_off_req = 1'b0;
  int          burst_left = 0;
  int          gap_max = 3;
  logic [7:0]  last_node = 8'd1;
  logic [31:0] t_us;
  logic [31:0] up_of  [256];
  logic [63:0] idh_of [256];
  logic [63:0] idl_of [256];

  bus_node_presence_table #(.NODE_SLOTS(NODE_SLOTS)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_node_id          (in_node_id),
    .in_now_us           (in_now_us),
    .in_uptime_sec       (in_uptime_sec),
    .in_uuid_high        (in_uuid_high),
    .in_uuid_low         (in_uuid_low),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_request_info    (out_request_info),
    .out_request_node_id (out_request_node_id),
    .out_match_found     (out_match_found)
  );

  presence_table_checker #(.NODE_SLOTS(NODE_SLOTS)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_node_id          (in_node_id),
    .in_now_us           (in_now_us),
    .in_uptime_sec       (in_uptime_sec),
    .in_uuid_high        (in_uuid_high),
    .in_uuid_low         (in_uuid_low),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_request_info    (out_request_info),
    .out_request_node_id (out_request_node_id),
    .out_match_found     (out_match_found),
    .fail_count          (fail_count),
    .outstanding         (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // The receiver redraws its stall rate whenever a random-length stall run ends and serves one
  // long hold-off on request so that the block backs up into its input.
  initial begin
    int pct;
    int stall_left;
    pct = 0;
    stall_left = 0;
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (stall_left == 0) begin
          case ($urandom_range(3))
            0: pct = 0;
            1: pct = 10;
            2: pct = 50;
            default: pct = 90;
          endcase
          stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        out_stall <= ($urandom_range(99) < pct);
        @(posedge clk);
      end
    end
  end

  // Offers one transaction and waits for the edge that accepts it. Between
  // bursts the sender then drops valid for a random gap before returning.
  task automatic offer(input op_t op, input logic [7:0] node, input logic [31:0] now,
                       input logic [31:0] up, input logic [63:0] idh,
                       input logic [63:0] idl);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_node_id    <= node;
    in_now_us     <= now;
    in_uptime_sec <= up;
    in_uuid_high  <= idh;
    in_uuid_low   <= idl;
    do @(posedge clk); while (in_stall);
    if (gap_max == 0 || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeouts(input logic [31:0] stale, input logic [31:0] expire);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STALE;
    cfg_wdata <= stale;
    @(posedge clk);
    cfg_index <= CFG_EXPIRE;
    cfg_wdata <= expire;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_node();
    int r;
    r = $urandom_range(99);
    if (r < 40) return last_node;
    if (r < 85) return 8'($urandom_range(1, 6));
    if (r < 92) return 8'd127;
    return 8'($urandom_range(1, 127));
  endfunction

  // Mostly well-formed traffic on a small pool of nodes: info responses,
  // status events with rising uptime and queries with the id last given,
  // mixed with uptime drops, near-miss ids, cleanup ticks and noise.
  task automatic random_traffic(input int count, input logic [31:0] span);
    logic [7:0]  node;
    logic [31:0] up;
    logic [63:0] idh;
    logic [63:0] idl;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      node = pick_node();
      last_node = node;
      if ($urandom_range(1)) t_us += $urandom_range(0, span);
      idh = idh_of[node];
      idl = idl_of[node];
      up  = up_of[node];
      if (pick < 30) begin
        up += $urandom_range(0, 2);
        up_of[node] = up;
        offer(OP_STATUS, node, t_us, up, idh, idl);
      end else if (pick < 45) begin
        if ($urandom_range(3) == 0) begin
          idh = {$urandom, $urandom};
          idl = {$urandom, $urandom};
          idh_of[node] = idh;
          idl_of[node] = idl;
        end
        up += $urandom_range(0, 2);
        up_of[node] = up;
        offer(OP_INFO, node, t_us, up, idh, idl);
      end else if (pick < 60) begin
        offer(OP_QUERY, node, t_us, up, idh, idl);
      end else if (pick < 65) begin
        if ($urandom_range(1)) idh ^= 64'd1 << $urandom_range(63);
        else idl ^= 64'd1 << $urandom_range(63);
        offer(OP_QUERY, node, t_us, up, idh, idl);
      end else if (pick < 70) begin
        offer(OP_CLEANUP, node, t_us, up, idh, idl);
      end else if (pick < 80) begin
        offer(OP_STATUS, node, t_us, up - $urandom_range(1, 3), idh, idl);
      end else begin
        offer(op_t'($urandom_range(3)), 8'($urandom_range(255)), $urandom, $urandom,
              {$urandom, $urandom}, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_STALE;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_op         <= OP_STATUS;
    in_node_id    <= '0;
    in_now_us     <= '0;
    in_uptime_sec <= '0;
    in_uuid_high  <= '0;
    in_uuid_low   <= '0;
    for (int i = 0; i < 256; i++) begin
      up_of[i]  = '0;
      idh_of[i] = {$urandom, $urandom};
      idl_of[i] = {$urandom, $urandom};
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset timeouts.
    offer(OP_QUERY, 8'd5, 32'd0, 32'd0, 64'd0, 64'd0);
    offer(OP_STATUS, 8'd5, 32'd100, 32'd1, 64'd0, 64'd0);
    offer(OP_INFO, 8'd5, 32'd1000, 32'd10, 64'h0123_4567_89AB_CDEF,
          64'hFEDC_BA98_7654_3210);
    offer(OP_QUERY, 8'd5, 32'd1000, 32'd0, 64'h0123_4567_89AB_CDEF,
          64'hFEDC_BA98_7654_3210);
    offer(OP_QUERY, 8'd5, 32'd1000, 32'd0, 64'h0123_4567_89AB_CDEF,
          64'hFEDC_BA98_7654_3211);
    offer(OP_QUERY, 8'd5, 32'd1000, 32'd0, 64'h8123_4567_89AB_CDEF,
          64'hFEDC_BA98_7654_3210);
    // A status exactly at the stale limit refreshes; one past it does not.
    offer(OP_STATUS, 8'd5, 32'd10_001_000, 32'd10, 64'd0, 64'd0);
    offer(OP_STATUS, 8'd5, 32'd20_001_001, 32'd11, 64'd0, 64'd0);
    offer(OP_INFO, 8'd1, 32'hFFFF_FF00, 32'hFFFF_FFFF, '1, '1);
    offer(OP_STATUS, 8'd1, 32'h0000_0100, 32'hFFFF_FFFF, '1, '1);
    offer(OP_STATUS, 8'd1, 32'h0000_0200, 32'hFFFF_FFFE, '1, '1);
    offer(OP_INFO, 8'd127, 32'h0000_0100, 32'd0, 64'd0, 64'd0);
    offer(OP_QUERY, 8'd127, 32'h0000_0100, 32'd0, 64'd0, 64'd0);
    offer(OP_STATUS, 8'd0, 32'h0000_0100, 32'd0, 64'd0, 64'd0);
    offer(OP_STATUS, 8'd128, 32'h0000_0100, 32'd0, 64'd0, 64'd0);
    offer(OP_INFO, 8'd255, 32'h0000_0100, 32'd5, '1, '1);
    offer(OP_QUERY, 8'd128, 32'h0000_0100, 32'd0, 64'd0, 64'd0);
    // Cleanup exactly at the expire limit keeps the entry; one past it clears.
    offer(OP_CLEANUP, 8'd127, 32'h0000_0100 + 32'd4_000_000, 32'd0, 64'd0, 64'd0);
    offer(OP_QUERY, 8'd127, 32'h0000_0100, 32'd0, 64'd0, 64'd0);
    offer(OP_CLEANUP, 8'd0, 32'h0000_0100 + 32'd4_000_001, '1, '1, '1);
    offer(OP_QUERY, 8'd127, 32'h0000_0100, 32'd0, 64'd0, 64'd0);
    offer(OP_INFO, 8'd5, 32'd5000, 32'd7, 64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA);
    offer(OP_STATUS, 8'd5, 32'd6000, 32'd7, 64'd0, 64'd0);

    t_us = $urandom;
    gap_max = 8;
    random_traffic(300, 32'd3_000_000);

    set_timeouts(32'd0, 32'd0);
    gap_max = 0;
    random_traffic(200, 32'd1);

    set_timeouts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    gap_max = 2;
    random_traffic(200, 32'hFFFF_FFFF);

    set_timeouts(32'd1000, 32'd400);
    gap_max = 20;
    hold_off_req = 1'b1;
    random_traffic(250, 32'd300);

    set_timeouts($urandom_range(5000), $urandom_range(5000));
    gap_max = 6;
    random_traffic(250, 32'd400);

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bnp_pkg.sv
hw/rtl/bnp_ram.sv
hw/rtl/bnp_ctrl.sv
hw/rtl/bnp_dp.sv
hw/rtl/bus_node_presence_table.sv
dv/presence_table_checker.sv
dv/tb_top.sv
